FILE: rtl/fbib_pkg.sv
// Shared types and constants for the fitted bitmap icon blitter.
`default_nettype none
package fbib_pkg;

    // Request kinds on the input channel
    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_START = 2'd1,
        K_STEP  = 2'd2
    } t_kind;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FIT,
        S_TH,
        S_TW,
        S_ORG,
        S_SX,
        S_SY,
        S_ADDR,
        S_RD,
        S_OUT
    } t_state;

    localparam int SIDE_W = 8;   // icon side
    localparam int TGT_W  = 10;  // target side, box side
    localparam int POS_W  = 13;  // destination position
    localparam int CTR_W  = 12;  // center coordinate
    localparam int IDX_W  = 14;  // byte index, valid byte count
    localparam int COL_W  = 16;  // color
    localparam int DIV_W  = SIDE_W + TGT_W;  // dividend / quotient width
    localparam int RB_W   = 6;   // bytes per source row
    localparam logic [2:0] PIX_MSB = 3'd7;   // leftmost pixel bit
    localparam int PIX_PER_BYTE = 8;

    // Request to the shared divider
    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [TGT_W-1:0]   divisor;
    } t_div_req;

endpackage
`default_nettype wire

FILE: rtl/fbib_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fbib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/fbib_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module fbib_div
    import fbib_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo;
    logic [TGT_W-1:0] r_rem;
    logic [TGT_W-1:0] r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [TGT_W:0]   w_shift;
    logic [TGT_W+1:0] w_diff;
    logic             w_ge;

    // Trial subtract of the divisor from the shifted remainder
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b0, r_dsr};
    assign w_ge    = !w_diff[TGT_W+1];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[TGT_W-1:0] : w_shift[TGT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

FILE: rtl/fitted_bitmap_icon_blitter_core.sv
// Icon blitter: loads a 1 bpp bitmap, fits it into a box, streams scaled pixels.
// Load: a store write. Start: no divider pass when the icon fits or is empty, one pass
// of the shared 18-step divider when it is scaled by width, two when the height clamps.
// Step: two divider passes plus address and store read, then the pixel waits for a free
// output slot; next request is taken the cycle after the result is registered.
// Reset is synchronous and clears control state; the bitmap store is not cleared.
`default_nettype none
module fitted_bitmap_icon_blitter_core
    import fbib_pkg::*;
#(
    parameter int STORE_BYTES = 8192,
    parameter int MAX_SIDE    = 255
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // request channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [1:0]               i_kind,
    input  wire logic [12:0]              i_byte_address,
    input  wire logic [7:0]               i_byte_value,
    input  wire logic [SIDE_W-1:0]        i_icon_width,
    input  wire logic [SIDE_W-1:0]        i_icon_height,
    input  wire logic [IDX_W-1:0]         i_data_bytes,
    input  wire logic signed [CTR_W-1:0]  i_center_x,
    input  wire logic signed [CTR_W-1:0]  i_center_y,
    input  wire logic [TGT_W-1:0]         i_box_width,
    input  wire logic [TGT_W-1:0]         i_box_height,
    input  wire logic [COL_W-1:0]         i_color,
    // pixel channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [POS_W-1:0]       o_pixel_x,
    output logic signed [POS_W-1:0]       o_pixel_y,
    output logic                          o_pixel_on,
    output logic [COL_W-1:0]              o_pixel_color,
    output logic                          o_last
);

    localparam int AW = $clog2(STORE_BYTES);

    t_state r_state, n_state;

    logic [SIDE_W-1:0]        r_w, n_w, r_h, n_h;
    logic [IDX_W-1:0]         r_vbytes, n_vbytes;
    logic [TGT_W-1:0]         r_tw, n_tw, r_th, n_th;
    logic [TGT_W-1:0]         r_bw, n_bw, r_bh, n_bh;
    logic signed [CTR_W-1:0]  r_cx, n_cx, r_cy, n_cy;
    logic signed [POS_W-1:0]  r_ox, n_ox, r_oy, n_oy;
    logic [TGT_W-1:0]         r_col, n_col, r_row, n_row;
    logic [COL_W-1:0]         r_color, n_color;
    logic                     r_drawing, n_drawing;
    logic [SIDE_W-1:0]        r_sx, n_sx, r_sy, n_sy;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_inrng, n_inrng;

    logic                     r_out_valid, n_out_valid;
    logic signed [POS_W-1:0]  r_px, n_px, r_py, n_py;
    logic                     r_on, n_on, r_last, n_last;
    logic [COL_W-1:0]         r_pcolor, n_pcolor;

    t_div_req                 w_div_req;
    logic                     w_div_done;
    logic [DIV_W-1:0]         w_quo;

    logic [TGT_W-1:0]         w_mul_a;
    logic [SIDE_W-1:0]        w_mul_b;
    logic [DIV_W-1:0]         w_product;

    logic                     w_ram_we;
    logic [7:0]               w_rdata;
    logic [SIDE_W:0]          w_rb_sum;
    logic [RB_W-1:0]          w_row_bytes;
    logic [IDX_W-1:0]         w_idx;
    logic                     w_bit;
    logic                     w_col_end, w_row_end;

    // Shared multiplier feeding the divider: operands chosen by state
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_IDLE:  begin w_mul_a = r_col; w_mul_b = r_w; end
            S_FIT:   begin w_mul_a = r_bw;  w_mul_b = r_h; end
            S_TH:    begin w_mul_a = r_bh;  w_mul_b = r_w; end
            S_SX:    begin w_mul_a = r_row; w_mul_b = r_h; end
            default: ;
        endcase
    end
    assign w_product = w_mul_a * w_mul_b;

    // Source byte index: row * bytes per row + column / 8
    assign w_rb_sum    = {1'b0, r_w} + (SIDE_W+1)'(PIX_MSB);
    assign w_row_bytes = w_rb_sum[SIDE_W:3];
    assign w_idx       = IDX_W'(r_sy) * IDX_W'(w_row_bytes) + IDX_W'(r_sx / PIX_PER_BYTE);

    // Pixel bit of the fetched byte, leftmost pixel in the MSB
    assign w_bit = w_rdata[PIX_MSB - r_sx[2:0]];

    assign w_col_end = ({1'b0, r_col} + 1'b1) == {1'b0, r_tw};
    assign w_row_end = ({1'b0, r_row} + 1'b1) == {1'b0, r_th};

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_h         = r_h;
        n_vbytes    = r_vbytes;
        n_tw        = r_tw;
        n_th        = r_th;
        n_bw        = r_bw;
        n_bh        = r_bh;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_col       = r_col;
        n_row       = r_row;
        n_color     = r_color;
        n_drawing   = r_drawing;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_idx       = r_idx;
        n_inrng     = r_inrng;
        n_px        = r_px;
        n_py        = r_py;
        n_on        = r_on;
        n_last      = r_last;
        n_pcolor    = r_pcolor;
        w_ram_we    = 1'b0;
        w_div_req   = '0;
        w_div_req.dividend = w_product;

        // output register drains when taken
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_kind)
                        K_LOAD: begin
                            w_ram_we = 32'(i_byte_address) < STORE_BYTES;
                        end
                        K_START: begin
                            n_w = ({2'b0, i_icon_width} > TGT_W'(MAX_SIDE)) ?
                                  SIDE_W'(MAX_SIDE) : i_icon_width;
                            n_h = ({2'b0, i_icon_height} > TGT_W'(MAX_SIDE)) ?
                                  SIDE_W'(MAX_SIDE) : i_icon_height;
                            n_vbytes  = i_data_bytes;
                            n_color   = i_color;
                            n_cx      = i_center_x;
                            n_cy      = i_center_y;
                            n_bw      = i_box_width;
                            n_bh      = i_box_height;
                            n_col     = '0;
                            n_row     = '0;
                            n_drawing = 1'b0;
                            n_state   = S_FIT;
                        end
                        K_STEP: begin
                            if (r_drawing) begin
                                w_div_req.start   = 1'b1;
                                w_div_req.divisor = r_tw;
                                n_state           = S_SX;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // fit test: empty, unscaled, or scale by width first
            S_FIT: begin
                if (r_w == '0 || r_h == '0) begin
                    n_tw    = '0;
                    n_th    = '0;
                    n_state = S_ORG;
                end else if ({2'b0, r_w} <= r_bw && {2'b0, r_h} <= r_bh) begin
                    n_tw    = {2'b0, r_w};
                    n_th    = {2'b0, r_h};
                    n_state = S_ORG;
                end else begin
                    w_div_req.start   = 1'b1;
                    w_div_req.divisor = {2'b0, r_w};
                    n_state           = S_TH;
                end
            end
            // height from width; clamp and rescale width when too tall
            S_TH: begin
                if (w_div_done) begin
                    if (w_quo > DIV_W'(r_bh)) begin
                        n_th              = r_bh;
                        w_div_req.start   = 1'b1;
                        w_div_req.divisor = {2'b0, r_h};
                        n_state           = S_TW;
                    end else begin
                        n_th    = w_quo[TGT_W-1:0];
                        n_tw    = r_bw;
                        n_state = S_ORG;
                    end
                end
            end
            S_TW: begin
                if (w_div_done) begin
                    n_tw    = w_quo[TGT_W-1:0];
                    n_state = S_ORG;
                end
            end
            // origin is center minus half the target
            S_ORG: begin
                n_ox = $signed({r_cx[CTR_W-1], r_cx}) -
                       $signed({(POS_W-TGT_W+1)'(0), r_tw[TGT_W-1:1]});
                n_oy = $signed({r_cy[CTR_W-1], r_cy}) -
                       $signed({(POS_W-TGT_W+1)'(0), r_th[TGT_W-1:1]});
                n_drawing = (r_tw != '0) && (r_th != '0);
                n_state   = S_IDLE;
            end
            // nearest source column, then source row
            S_SX: begin
                if (w_div_done) begin
                    n_sx              = w_quo[SIDE_W-1:0];
                    w_div_req.start   = 1'b1;
                    w_div_req.divisor = r_th;
                    n_state           = S_SY;
                end
            end
            S_SY: begin
                if (w_div_done) begin
                    n_sy    = w_quo[SIDE_W-1:0];
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_idx   = w_idx;
                n_inrng = (w_idx < r_vbytes) && (32'(w_idx) < STORE_BYTES);
                n_state = S_RD;
            end
            // store read in flight
            S_RD: begin
                n_state = S_OUT;
            end
            // register the pixel once the output slot is free
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_px        = r_ox + $signed({(POS_W-TGT_W)'(0), r_col});
                    n_py        = r_oy + $signed({(POS_W-TGT_W)'(0), r_row});
                    n_on        = r_inrng && w_bit;
                    n_pcolor    = r_color;
                    n_last      = w_col_end && w_row_end;
                    if (w_col_end && w_row_end) begin
                        n_drawing = 1'b0;
                        n_col     = '0;
                        n_row     = '0;
                    end else if (w_col_end) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Draw state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawing   <= 1'b0;
            r_out_valid <= 1'b0;
            r_w         <= '0;
            r_h         <= '0;
            r_vbytes    <= '0;
            r_tw        <= '0;
            r_th        <= '0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_color     <= '0;
        end else begin
            r_drawing   <= n_drawing;
            r_out_valid <= n_out_valid;
            r_w         <= n_w;
            r_h         <= n_h;
            r_vbytes    <= n_vbytes;
            r_tw        <= n_tw;
            r_th        <= n_th;
            r_ox        <= n_ox;
            r_oy        <= n_oy;
            r_col       <= n_col;
            r_row       <= n_row;
            r_color     <= n_color;
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        r_bw     <= n_bw;
        r_bh     <= n_bh;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_idx    <= n_idx;
        r_inrng  <= n_inrng;
        r_px     <= n_px;
        r_py     <= n_py;
        r_on     <= n_on;
        r_last   <= n_last;
        r_pcolor <= n_pcolor;
    end

    fbib_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    fbib_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(i_byte_address)),
        .i_wdata (i_byte_value),
        .i_raddr (AW'(r_idx)),
        .o_rdata (w_rdata)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_on    = r_on;
    assign o_pixel_color = r_pcolor;
    assign o_last        = r_last;

endmodule
`default_nettype wire

FILE: sim/fitted_bitmap_icon_blitter_core_tb.sv
// Self-checking testbench for the fitted bitmap icon blitter core.
module fitted_bitmap_icon_blitter_core_tb;
    import fbib_pkg::*;

    localparam int STORE_N      = 8192;
    localparam int STORE_AW     = $clog2(STORE_N);
    localparam int RAND_ITEMS   = 1900;
    localparam int GAP_MAX      = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_EVERY   = 300;
    localparam int HOLD_RUNS    = 2;
    localparam int DRAIN_CYCLES = 100;
    localparam int STEP_CAP     = 48;
    localparam int FILL_SLACK   = 64;
    localparam int MAX_REPORTS  = 10;
    localparam logic [1:0] K_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]              kind;
        logic [12:0]             addr;
        logic [7:0]              value;
        logic [SIDE_W-1:0]       width;
        logic [SIDE_W-1:0]       height;
        logic [IDX_W-1:0]        nbytes;
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic [TGT_W-1:0]        bw;
        logic [TGT_W-1:0]        bh;
        logic [COL_W-1:0]        color;
    } t_blit_req;

    typedef struct {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             on;
        logic [COL_W-1:0] color;
        logic             last;
    } t_pixel;

    // DUT connections
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_kind = '0;
    logic [12:0]              i_byte_address = '0;
    logic [7:0]               i_byte_value = '0;
    logic [SIDE_W-1:0]        i_icon_width = '0;
    logic [SIDE_W-1:0]        i_icon_height = '0;
    logic [IDX_W-1:0]         i_data_bytes = '0;
    logic signed [CTR_W-1:0]  i_center_x = '0;
    logic signed [CTR_W-1:0]  i_center_y = '0;
    logic [TGT_W-1:0]         i_box_width = '0;
    logic [TGT_W-1:0]         i_box_height = '0;
    logic [COL_W-1:0]         i_color = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [POS_W-1:0]  o_pixel_x;
    logic signed [POS_W-1:0]  o_pixel_y;
    logic                     o_pixel_on;
    logic [COL_W-1:0]         o_pixel_color;
    logic                     o_last;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fitted_bitmap_icon_blitter_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_byte_address (i_byte_address),
        .i_byte_value   (i_byte_value),
        .i_icon_width   (i_icon_width),
        .i_icon_height  (i_icon_height),
        .i_data_bytes   (i_data_bytes),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_box_width    (i_box_width),
        .i_box_height   (i_box_height),
        .i_color        (i_color),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_on     (o_pixel_on),
        .o_pixel_color  (o_pixel_color),
        .o_last         (o_last)
    );

    // Predictor state: bitmap copy, latched draw setup, scan position
    logic [7:0]       pic_bytes [STORE_N];
    int unsigned      src_w = 0, src_h = 0, valid_n = 0;
    int unsigned      tgt_w = 0, tgt_h = 0, col = 0, row = 0;
    int               org_x = 0, org_y = 0;
    logic [COL_W-1:0] draw_color = '0;
    bit               busy = 1'b0;
    t_pixel           pixel_expect [$];
    int               err_count = 0;

    // Target size: icon size if it fits, else aspect-kept and clamped to the box
    function automatic void fit_target(input int unsigned w, h, bw, bh,
                                       output int unsigned tw, th);
        tw = 0;
        th = 0;
        if (w != 0 && h != 0) begin
            if (w <= bw && h <= bh) begin
                tw = w;
                th = h;
            end else begin
                tw = bw;
                th = (h * bw) / w;
                if (th > bh) begin
                    th = bh;
                    tw = (w * bh) / h;
                end
            end
        end
    endfunction

    // Apply one accepted request; a step while drawing yields one pixel
    function automatic void blit_predict(input t_blit_req r);
        int unsigned sx, sy, idx;
        t_pixel      px;
        case (r.kind)
            K_LOAD: pic_bytes[r.addr] = r.value;
            K_START: begin
                src_w      = 32'(r.width);
                src_h      = 32'(r.height);
                valid_n    = 32'(r.nbytes);
                draw_color = r.color;
                col        = 0;
                row        = 0;
                fit_target(src_w, src_h, 32'(r.bw), 32'(r.bh), tgt_w, tgt_h);
                org_x = int'(r.cx) - int'(tgt_w / 2);
                org_y = int'(r.cy) - int'(tgt_h / 2);
                busy  = (tgt_w != 0) && (tgt_h != 0);
            end
            K_STEP: begin
                if (busy) begin
                    // nearest-neighbor source pixel
                    sx  = (col * src_w) / tgt_w;
                    sy  = (row * src_h) / tgt_h;
                    idx = sy * ((src_w + PIX_PER_BYTE - 1) / PIX_PER_BYTE)
                          + sx / PIX_PER_BYTE;
                    px.x     = POS_W'(org_x + int'(col));
                    px.y     = POS_W'(org_y + int'(row));
                    px.on    = (idx < valid_n) && (idx < STORE_N)
                               && pic_bytes[STORE_AW'(idx)][PIX_MSB - 3'(sx)];
                    px.color = draw_color;
                    px.last  = (col + 1 == tgt_w) && (row + 1 == tgt_h);
                    pixel_expect.push_back(px);
                    if (px.last) begin
                        busy = 1'b0;
                        col  = 0;
                        row  = 0;
                    end else if (col + 1 == tgt_w) begin
                        col = 0;
                        row++;
                    end else begin
                        col++;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic void check_pixel();
        t_pixel px;
        if (pixel_expect.size() == 0) begin
            flag_error($sformatf("unexpected pixel x=%0d y=%0d", o_pixel_x, o_pixel_y));
            return;
        end
        px = pixel_expect.pop_front();
        if (px.x !== o_pixel_x || px.y !== o_pixel_y || px.on !== o_pixel_on
                || px.color !== o_pixel_color || px.last !== o_last)
            flag_error({
                $sformatf("pixel mismatch: exp x=%0d y=%0d on=%b color=%h last=%b,",
                          $signed(px.x), $signed(px.y), px.on, px.color, px.last),
                $sformatf(" got x=%0d y=%0d on=%b color=%h last=%b",
                          o_pixel_x, o_pixel_y, o_pixel_on, o_pixel_color, o_last)});
    endfunction

    // Request generation; tracks which store bytes are loaded so no draw
    // ever reads a byte that was never written
    t_blit_req req_queue [$];
    bit        loaded_map [STORE_N];
    int        loaded_top = 0;
    int        gen_items = 0;

    function automatic t_blit_req rand_req(input logic [1:0] kind);
        t_blit_req r;
        r.kind   = kind;
        r.addr   = 13'($urandom);
        r.value  = 8'($urandom);
        r.width  = SIDE_W'($urandom);
        r.height = SIDE_W'($urandom);
        r.nbytes = IDX_W'($urandom_range(0, STORE_N));
        r.cx     = CTR_W'($urandom);
        r.cy     = CTR_W'($urandom);
        r.bw     = TGT_W'($urandom);
        r.bh     = TGT_W'($urandom);
        r.color  = COL_W'($urandom);
        return r;
    endfunction

    function automatic void queue_load(input int addr, input logic [7:0] value);
        t_blit_req r;
        r       = rand_req(K_LOAD);
        r.addr  = 13'(addr);
        r.value = value;
        req_queue.push_back(r);
        loaded_map[STORE_AW'(addr)] = 1'b1;
        while (loaded_top < STORE_N && loaded_map[STORE_AW'(loaded_top)])
            loaded_top++;
        gen_items++;
    endfunction

    function automatic void queue_steps(input int n);
        for (int i = 0; i < n; i++)
            req_queue.push_back(rand_req(K_STEP));
        gen_items += n;
    endfunction

    // Returns the number of pixels in the resulting target
    function automatic int queue_start(input int w, h, nb, cx, cy, bw, bh, color);
        t_blit_req   r;
        int unsigned tw, th;
        int          need;
        r        = rand_req(K_START);
        r.width  = SIDE_W'(w);
        r.height = SIDE_W'(h);
        r.nbytes = IDX_W'(nb);
        r.cx     = CTR_W'(cx);
        r.cy     = CTR_W'(cy);
        r.bw     = TGT_W'(bw);
        r.bh     = TGT_W'(bh);
        r.color  = COL_W'(color);
        // bytes the draw can read: below both the valid count and the bitmap end
        need = h * ((w + PIX_PER_BYTE - 1) / PIX_PER_BYTE);
        if (nb < need)
            need = nb;
        while (loaded_top < need)
            queue_load(loaded_top, 8'($urandom));
        req_queue.push_back(r);
        gen_items++;
        fit_target(w, h, bw, bh, tw, th);
        return tw * th;
    endfunction

    function automatic int pick_side();
        case ($urandom_range(0, 19))
            0:       return 0;
            1, 2:    return $urandom_range(0, 255);
            default: return $urandom_range(1, 10);
        endcase
    endfunction

    function automatic int pick_center();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1) ? 2047 : -2048;
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int queue_random_start();
        int w, h, nb, bw, bh, full;
        w    = pick_side();
        h    = pick_side();
        bw   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 12);
        bh   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 12);
        full = h * ((w + PIX_PER_BYTE - 1) / PIX_PER_BYTE);
        case ($urandom_range(0, 3))
            0:       nb = full;
            1:       nb = STORE_N;
            2:       nb = $urandom_range(0, full);
            default: nb = $urandom_range(0, STORE_N);
        endcase
        // keep the loaded region growing slowly for tall, wide icons
        if (nb > loaded_top + FILL_SLACK && full > loaded_top + FILL_SLACK)
            nb = $urandom_range(0, loaded_top + FILL_SLACK);
        return queue_start(w, h, nb, pick_center(), pick_center(), bw, bh, $urandom);
    endfunction

    // Idle cycles per request; every fourth stretch runs back to back
    function automatic int draw_gap(input int n);
        if ((n / 200) % 4 == 3)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // Request driver: changes inputs on the falling edge, holds while stalled
    t_blit_req cur_req;
    int        req_sent = 0, req_taken = 0, tx_gap = 0;

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && req_taken != req_sent)) begin
            if (tx_gap != 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (req_queue.size() != 0) begin
                cur_req = req_queue.pop_front();
                i_kind         <= cur_req.kind;
                i_byte_address <= cur_req.addr;
                i_byte_value   <= cur_req.value;
                i_icon_width   <= cur_req.width;
                i_icon_height  <= cur_req.height;
                i_data_bytes   <= cur_req.nbytes;
                i_center_x     <= cur_req.cx;
                i_center_y     <= cur_req.cy;
                i_box_width    <= cur_req.bw;
                i_box_height   <= cur_req.bh;
                i_color        <= cur_req.color;
                i_in_valid     <= 1'b1;
                req_sent++;
                tx_gap = draw_gap(req_sent);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check pixels, predict from accepted requests
    int rx_count = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_pixel();
                rx_count <= rx_count + 1;
            end
            if (i_in_valid && !o_in_stall) begin
                blit_predict(cur_req);
                req_taken <= req_taken + 1;
            end
        end
    end

    // Long receiver hold-offs so the block backs up into its input
    bit hold_active = 1'b0;
    int hold_left = 0, hold_runs = 0;

    always @(posedge i_clk) begin
        if (hold_active) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                hold_active <= 1'b0;
        end else if (hold_runs < HOLD_RUNS && rx_count >= (hold_runs + 1) * HOLD_EVERY) begin
            hold_active <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_runs   <= hold_runs + 1;
        end
    end

    // Receiver stall: random wait after each pixel, plus the hold-offs
    int rx_seen = 0, rx_gap = 0;

    always @(negedge i_clk) begin
        if (rx_count != rx_seen) begin
            rx_seen = rx_count;
            rx_gap  = draw_gap(rx_seen);
        end
        i_out_stall <= hold_active || (rx_gap != 0);
        if (rx_gap != 0)
            rx_gap--;
    end

    initial begin
        int area, n, addr;

        // Directed: idle step, unknown kind, fitted draw at the center extremes
        queue_steps(1);
        req_queue.push_back(rand_req(K_UNUSED));
        queue_load(0, 8'hFF);
        queue_load(1, 8'hA0);
        void'(queue_start(3, 2, 2, -2048, 2047, 1023, 1023, 16'hFFFF));
        queue_steps(7);
        // largest icon scaled into a tiny box, no valid bytes
        void'(queue_start(255, 255, 0, 2047, -2048, 2, 3, 16'h0000));
        queue_steps(4);
        // tall icon whose scaled width rounds down to nothing
        void'(queue_start(2, 9, 16, 0, 0, 5, 3, 16'h1234));
        // zero icon side, then a zero box
        void'(queue_start(0, 5, 8, 100, -100, 1023, 1023, 16'h00FF));
        queue_steps(1);
        void'(queue_start(5, 5, 8, 0, 0, 0, 0, 16'hF800));
        // start while drawing drops the draw in progress
        void'(queue_start(9, 1, STORE_N, -1, 1, 1023, 1023, 16'h07E0));
        queue_steps(2);
        void'(queue_start(1, 1, 1, 10, 10, 1, 1, 16'h001F));
        queue_steps(1);
        // load while drawing is seen by later pixels
        void'(queue_start(2, 2, 2, -5, 5, 1023, 1023, 16'hAAAA));
        queue_steps(2);
        queue_load(1, 8'hC0);
        queue_steps(2);

        // Random: mostly complete or partial draws, some noise
        while (gen_items < RAND_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                repeat ($urandom_range(0, 3)) begin
                    addr = $urandom_range(0, loaded_top + 4);
                    if (addr > STORE_N - 1)
                        addr = STORE_N - 1;
                    queue_load(addr, 8'($urandom));
                end
                area = queue_random_start();
                n = area;
                if (n > STEP_CAP)
                    n = $urandom_range(1, STEP_CAP);
                else if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(0, n);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        addr = $urandom_range(0, loaded_top);
                        if (addr > STORE_N - 1)
                            addr = STORE_N - 1;
                        queue_load(addr, 8'($urandom));
                    end
                    queue_steps(1);
                end
                if ($urandom_range(0, 5) == 0)
                    queue_steps($urandom_range(1, 2));
            end else begin
                case ($urandom_range(0, 3))
                    0:       queue_load($urandom_range(0, STORE_N - 1), 8'($urandom));
                    1:       req_queue.push_back(rand_req(K_UNUSED));
                    2:       queue_steps(1);
                    default: void'(queue_random_start());
                endcase
            end
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all requests taken, all pixels seen, then a quiet tail
        while (req_queue.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (pixel_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("fitted_bitmap_icon_blitter_core_tb: PASS");
        else
            $display("fitted_bitmap_icon_blitter_core_tb: FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("fitted_bitmap_icon_blitter_core_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/fbib_pkg.sv
rtl/fbib_ram.sv
rtl/fbib_div.sv
rtl/fitted_bitmap_icon_blitter_core.sv
sim/fitted_bitmap_icon_blitter_core_tb.sv
